// ----- sv/fst_pkg.sv -----
// Shared types, constants and helpers for the fingerprinted slot table.
package fst_pkg;

  localparam int unsigned SlotCount = 64;
  localparam int unsigned SlotW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned FpW       = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotOutW  = 6;

  localparam logic [OpW-1:0] OpLookup = 2'd0;
  localparam logic [OpW-1:0] OpUpsert = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;

  typedef enum logic [StatusW-1:0] {
    StsFound    = 2'd0,
    StsMissing  = 2'd1,
    StsInserted = 2'd2,
    StsFull     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StCheck,
    StDone
  } state_e;

  typedef logic [SlotCount-1:0] slot_mask_t;
  typedef logic [SlotW-1:0]     slot_idx_t;

  // Update of the valid/fingerprint array.
  typedef struct packed {
    logic           set_valid;
    logic           clr_valid;
    slot_idx_t      idx;
    logic [FpW-1:0] fp;
  } tag_upd_t;

  // Status seen by the controller.
  typedef struct packed {
    slot_mask_t valid;
    slot_mask_t match;
    logic       free_found;
    slot_idx_t  free_idx;
  } tag_info_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic slot_idx_t lowest_set(slot_mask_t m);
    slot_idx_t idx;
    idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = slot_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/fingerprinted_slot_table_unit.sv -----
// Top level of the fingerprinted slot table: request control, key and value memories.
// Flow: an accepted request is captured with its fingerprint match mask; the matching slots
//   then have their keys read and checked in turn until one matches or none is left, and the
//   result waits for the output register. Probe, key check and result run in turn, and the
//   next request waits until the control is idle again.
// Reset: asynchronous, active low; clears all valid bits (table empty) and the control.
//   Key, value and fingerprint stores are not cleared; no clearing pass is needed.
module fingerprinted_slot_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fst_pkg::OpW-1:0]       op_i,
  input  logic [fst_pkg::KeyW-1:0]      key_i,
  input  logic [fst_pkg::FpW-1:0]       key_signature_i,
  input  logic [fst_pkg::ValueW-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fst_pkg::StatusW-1:0]   status_o,
  output logic [fst_pkg::SlotOutW-1:0]  slot_o,
  output logic [fst_pkg::ValueW-1:0]    read_value_o
);
  import fst_pkg::*;

  // Control state.
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Request held for the duration of the probe.
  logic [OpW-1:0]    op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [FpW-1:0]    fp_q, fp_d;
  logic [ValueW-1:0] value_q, value_d;
  slot_mask_t        mask_q, mask_d;   // candidates still to check
  slot_idx_t         cand_q, cand_d;   // slot whose key is in flight

  // Finished result, and the output register it moves into.
  status_e           res_status_q, res_status_d;
  slot_idx_t         res_slot_q, res_slot_d;
  logic [ValueW-1:0] res_value_q, res_value_d;
  status_e           out_status_q, out_status_d;
  slot_idx_t         out_slot_q, out_slot_d;
  logic [ValueW-1:0] out_value_q, out_value_d;

  // Array and memory controls.
  tag_upd_t          tag_upd;
  tag_info_t         tag_info;
  logic              key_we, val_we, mem_re;
  slot_idx_t         mem_waddr, mem_raddr;
  logic [ValueW-1:0] val_wdata;
  logic [KeyW-1:0]   key_rdata;
  logic [ValueW-1:0] val_rdata;

  logic in_fire, out_fire, op_known;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign op_known   = (op_q == OpLookup) || (op_q == OpUpsert) || (op_q == OpRemove);

  // Fingerprint compare runs on the incoming request so the match mask is
  // captured together with it.
  fst_tag_array u_tags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .query_fp_i (key_signature_i),
    .upd_i      (tag_upd),
    .info_o     (tag_info)
  );

  fst_ram #(
    .Depth (SlotCount),
    .Width (KeyW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (mem_waddr),
    .wdata_i (key_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (key_rdata)
  );

  fst_ram #(
    .Depth (SlotCount),
    .Width (ValueW)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (val_rdata)
  );

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    key_d        = key_q;
    fp_d         = fp_q;
    value_d      = value_q;
    mask_d       = mask_q;
    cand_d       = cand_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_value_d  = res_value_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_value_d  = out_value_q;

    tag_upd      = '0;
    key_we       = 1'b0;
    val_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cand_q;
    mem_raddr    = lowest_set(mask_q);
    val_wdata    = value_q;

    // Drop the result once the consumer takes it.
    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          op_d    = op_i;
          key_d   = key_i;
          fp_d    = key_signature_i;
          value_d = value_i;
          mask_d  = tag_info.match;
          state_d = StProbe;
        end
      end

      StProbe: begin
        if (!op_known || (mask_q == '0)) begin
          // No candidate left, or an unknown op: the key is treated as not in the table.
          res_value_d = '0;
          if (op_q == OpUpsert && tag_info.free_found) begin
            tag_upd.set_valid = 1'b1;
            tag_upd.idx       = tag_info.free_idx;
            tag_upd.fp        = fp_q;
            key_we            = 1'b1;
            val_we            = 1'b1;
            mem_waddr         = tag_info.free_idx;
            res_status_d      = StsInserted;
            res_slot_d        = tag_info.free_idx;
          end else if (op_q == OpUpsert) begin
            res_status_d = StsFull;
            res_slot_d   = '0;
          end else begin
            res_status_d = StsMissing;
            res_slot_d   = '0;
          end
          state_d = StDone;
        end else begin
          // Fetch key and value of the lowest remaining candidate.
          mem_re  = 1'b1;
          cand_d  = lowest_set(mask_q);
          state_d = StCheck;
        end
      end

      StCheck: begin
        if (key_rdata == key_q) begin
          res_status_d = StsFound;
          res_slot_d   = cand_q;
          res_value_d  = '0;
          case (op_q)
            OpLookup: res_value_d = val_rdata;
            OpUpsert: val_we = 1'b1;
            default: begin
              tag_upd.clr_valid = 1'b1;
              tag_upd.idx       = cand_q;
            end
          endcase
          state_d = StDone;
        end else begin
          // Fingerprint alias: drop this candidate and try the next.
          mask_d[cand_q] = 1'b0;
          state_d        = StProbe;
        end
      end

      StDone: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_value_d  = res_value_q;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    fp_q         <= fp_d;
    value_q      <= value_d;
    mask_q       <= mask_d;
    cand_q       <= cand_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_value_q  <= out_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = SlotOutW'(out_slot_q);
  assign read_value_o = out_value_q;

`ifndef SYNTH
  // The slot whose key is being checked is still a live candidate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) |-> mask_q[cand_q])
    else $error("checked slot is not a candidate");

  // An inserted slot is valid once the result is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && res_status_q == StsInserted) |-> tag_info.valid[res_slot_q])
    else $error("inserted slot not marked valid");

  // A removed slot is no longer valid once the result is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && op_q == OpRemove && res_status_q == StsFound)
      |-> !tag_info.valid[res_slot_q])
    else $error("removed slot still valid");

  // Only a successful lookup returns a nonzero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && (res_status_q != StsFound || op_q != OpLookup))
      |-> (res_value_q == '0))
    else $error("read value set without a lookup hit");

  // An accepted request always starts probing in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StProbe))
    else $error("accepted request did not start probing");
`endif

endmodule

// ----- sv/fst_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module fst_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fst_tag_array.sv -----
// Valid bits and fingerprints of all slots, with parallel match and free-slot search.
module fst_tag_array (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fst_pkg::FpW-1:0]   query_fp_i,
  input  fst_pkg::tag_upd_t         upd_i,
  output fst_pkg::tag_info_t        info_o
);
  import fst_pkg::*;

  slot_mask_t     valid_q, valid_d;
  logic [FpW-1:0] fp_q [SlotCount];

  always_comb begin
    valid_d = valid_q;
    if (upd_i.set_valid) begin
      valid_d[upd_i.idx] = 1'b1;
    end
    if (upd_i.clr_valid) begin
      valid_d[upd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.set_valid) begin
      fp_q[upd_i.idx] <= upd_i.fp;
    end
  end

  always_comb begin
    for (int i = 0; i < SlotCount; i++) begin
      info_o.match[i] = valid_q[i] && (fp_q[i] == query_fp_i);
    end
    info_o.valid      = valid_q;
    info_o.free_found = ~&valid_q;
    info_o.free_idx   = lowest_set(~valid_q);
  end

endmodule

// ----- bench/fingerprinted_slot_table_unit_test.sv -----
// Self-checking testbench for the fingerprinted slot table: directed rows, then random phases.
module fingerprinted_slot_table_unit_test;
  import fst_pkg::*;

  // Op code 3 has no meaning in the block; it must be ignored.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // Pool of keys used by the random part. The upper half of the pool gets
  // fingerprints from a tiny range, so many stored slots share one
  // fingerprint and the key-check loop walks several candidates.
  localparam int unsigned PoolSize     = 96;
  localparam int unsigned PhaseCount   = 13;
  localparam int unsigned PhaseLen     = 100;
  localparam int unsigned DrainCycles  = 150;

  typedef enum int {
    ModeFill,
    ModeMixed,
    ModeDrain
  } phase_mode_e;

  typedef struct {
    status_e             status;
    logic [SlotOutW-1:0] slot;
    logic [ValueW-1:0]   rd;
  } leaf_result_t;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [KeyW-1:0]   key;
    logic [FpW-1:0]    fp;
    logic [ValueW-1:0] val;
    bit                typed;
    leaf_result_t      want;
  } leaf_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [OpW-1:0]       op_i            = OpLookup;
  logic [KeyW-1:0]      key_i           = '0;
  logic [FpW-1:0]       key_signature_i = '0;
  logic [ValueW-1:0]    value_i         = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [SlotOutW-1:0]  slot_o;
  logic [ValueW-1:0]    read_value_o;

  // Shadow copy of the leaf node, advanced once per accepted request.
  bit                leaf_valid [SlotCount];
  logic [FpW-1:0]    leaf_fp    [SlotCount];
  logic [KeyW-1:0]   leaf_key   [SlotCount];
  logic [ValueW-1:0] leaf_value [SlotCount];

  leaf_result_t      pending_results[$];
  leaf_row_t         directed_rows[$];
  logic [KeyW-1:0]   pool_key [PoolSize];
  logic [FpW-1:0]    pool_fp  [PoolSize];
  int                mismatch_count = 0;
  bit                calm           = 1'b0;

  fingerprinted_slot_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .key_i           (key_i),
    .key_signature_i (key_signature_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .read_value_o    (read_value_o)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop in case the handshake hangs.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length for either side: mostly none or short, now and then long.
  // During a calm phase both sides run without any idling.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the shadow leaf and return the result it causes.
  // The hit is the lowest valid slot whose fingerprint and key both match;
  // an upsert miss takes the lowest free slot.
  function automatic leaf_result_t apply_leaf_request(logic [OpW-1:0] op,
                                                      logic [KeyW-1:0] key,
                                                      logic [FpW-1:0] fp,
                                                      logic [ValueW-1:0] val);
    leaf_result_t res;
    int           hit;
    int           free_idx;
    int           i;
    res.status = StsMissing;
    res.slot   = '0;
    res.rd     = '0;
    hit        = -1;
    free_idx   = -1;
    for (i = SlotCount - 1; i >= 0; i--) begin
      if (leaf_valid[i] && leaf_fp[i] == fp && leaf_key[i] == key) begin
        hit = i;
      end
      if (!leaf_valid[i]) begin
        free_idx = i;
      end
    end
    case (op)
      OpLookup: begin
        if (hit >= 0) begin
          res.status = StsFound;
          res.slot   = SlotOutW'(hit);
          res.rd     = leaf_value[hit];
        end
      end
      OpRemove: begin
        if (hit >= 0) begin
          leaf_valid[hit] = 1'b0;
          res.status      = StsFound;
          res.slot        = SlotOutW'(hit);
        end
      end
      OpUpsert: begin
        if (hit >= 0) begin
          leaf_value[hit] = val;
          res.status      = StsFound;
          res.slot        = SlotOutW'(hit);
        end else if (free_idx >= 0) begin
          leaf_valid[free_idx] = 1'b1;
          leaf_fp[free_idx]    = fp;
          leaf_key[free_idx]   = key;
          leaf_value[free_idx] = val;
          res.status           = StsInserted;
          res.slot             = SlotOutW'(free_idx);
        end else begin
          res.status = StsFull;
        end
      end
      default: begin
        // ignored op: nothing changes
      end
    endcase
    return res;
  endfunction

  // Present one request and hold it until accepted. Called at a rising
  // edge; in_valid_i gets exactly one assignment per edge, so a back-to-back
  // request keeps valid high instead of dropping and raising it.
  task automatic send_request(logic [OpW-1:0] op, logic [KeyW-1:0] key,
                              logic [FpW-1:0] fp, logic [ValueW-1:0] val,
                              bit typed, leaf_result_t want);
    int           gap;
    leaf_result_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    key_i           <= key;
    key_signature_i <= fp;
    value_i         <= val;
    do @(posedge clk_i); while (!in_ready_o);
    got = apply_leaf_request(op, key, fp, val);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic add_row(logic [OpW-1:0] op, logic [KeyW-1:0] key, logic [FpW-1:0] fp,
                         logic [ValueW-1:0] val, bit typed, status_e st,
                         logic [SlotOutW-1:0] slot, logic [ValueW-1:0] rd);
    leaf_row_t row;
    row.op          = op;
    row.key         = key;
    row.fp          = fp;
    row.val         = val;
    row.typed       = typed;
    row.want.status = st;
    row.want.slot   = slot;
    row.want.rd     = rd;
    directed_rows.push_back(row);
  endtask

  // Request side: directed rows, then random phases, then wait for drain.
  initial begin
    leaf_row_t       row;
    phase_mode_e     mode;
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [FpW-1:0]  fp;
    int              idx;
    int              r;
    int              n;
    leaf_result_t    none;

    none.status = StsMissing;
    none.slot   = '0;
    none.rd     = '0;
    for (idx = 0; idx < SlotCount; idx++) begin
      leaf_valid[idx] = 1'b0;
    end
    for (idx = 0; idx < PoolSize; idx++) begin
      pool_key[idx] = {$urandom, $urandom};
      pool_fp[idx]  = (idx < PoolSize / 2) ? FpW'($urandom_range(0, 255))
                                           : FpW'($urandom_range(0, 3));
    end

    // Directed rows; the expectation is typed in where it is obvious.
    add_row(OpLookup, '0, 8'h00, '0, 1, StsMissing, 0, '0);   // lookup in empty node
    add_row(OpRemove, '1, 8'hff, '1, 1, StsMissing, 0, '0);   // remove in empty node
    add_row(OpUnused, '1, 8'hff, '1, 1, StsMissing, 0, '0);   // unused op code
    add_row(OpUpsert, '0, 8'h00, '1, 1, StsInserted, 0, '0);  // first insert, slot 0
    add_row(OpUpsert, '1, 8'hff, '0, 1, StsInserted, 1, '0);  // all-ones key, slot 1
    add_row(OpLookup, '0, 8'h00, '0, 1, StsFound, 0, '1);
    add_row(OpLookup, '1, 8'hff, '1, 1, StsFound, 1, '0);
    add_row(OpLookup, '0, 8'hff, '0, 1, StsMissing, 0, '0);   // fingerprint does not match slot 0
    add_row(OpUpsert, '0, 8'h00, 64'h5a5a_5a5a_a5a5_a5a5, 1, StsFound, 0, '0);
    add_row(OpLookup, '0, 8'h00, '0, 0, StsFound, 0, '0);
    // Same fingerprint as slot 0 but another key: the key check must skip slot 0.
    add_row(OpUpsert, 64'h1234, 8'h00, 64'h1111, 0, StsFound, 0, '0);
    // Same key under another fingerprint lands in a slot of its own.
    add_row(OpUpsert, '0, 8'h80, 64'h8000_0000_0000_0001, 0, StsFound, 0, '0);
    add_row(OpLookup, 64'h1234, 8'h00, '0, 0, StsFound, 0, '0);
    add_row(OpRemove, '0, 8'h00, '0, 1, StsFound, 0, '0);
    add_row(OpLookup, '0, 8'h00, '0, 1, StsMissing, 0, '0);
    add_row(OpLookup, '0, 8'h80, '0, 0, StsFound, 0, '0);
    // Freed slot 0 is the lowest free slot again.
    add_row(OpUpsert, 64'haaaa_aaaa_aaaa_aaaa, 8'h55, 64'h5555_5555_5555_5555, 0,
            StsFound, 0, '0);
    add_row(OpUnused, 64'h1234, 8'h00, '1, 1, StsMissing, 0, '0); // ignored despite a hit
    add_row(OpRemove, 64'h1234, 8'h00, '0, 0, StsFound, 0, '0);
    add_row(OpRemove, 64'h1234, 8'h00, '0, 1, StsMissing, 0, '0);
    add_row(OpLookup, 64'haaaa_aaaa_aaaa_aaaa, 8'h55, '0, 0, StsFound, 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.op, row.key, row.fp, row.val, row.typed, row.want);
    end

    // Random phases rotate through fill, churn and drain mixes of requests. Every
    // fourth phase runs without idling on either side.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      mode = phase_mode_e'(ph % 3);
      calm = (ph % 4 == 3);
      for (int k = 0; k < PhaseLen; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          ModeFill:  op = (r < 70) ? OpUpsert : (r < 88) ? OpLookup :
                          (r < 96) ? OpRemove : OpUnused;
          ModeMixed: op = (r < 35) ? OpUpsert : (r < 70) ? OpLookup :
                          (r < 95) ? OpRemove : OpUnused;
          default:   op = (r < 10) ? OpUpsert : (r < 25) ? OpLookup :
                          (r < 97) ? OpRemove : OpUnused;
        endcase
        idx = $urandom_range(0, PoolSize - 1);
        key = pool_key[idx];
        fp  = pool_fp[idx];
        // Inject a few unknown keys and mismatched fingerprints.
        n = $urandom_range(0, 99);
        if (n < 4) begin
          key = {$urandom, $urandom};
        end else if (n < 8) begin
          fp = FpW'($urandom_range(0, 255));
        end
        send_request(op, key, fp, {$urandom, $urandom}, 0, none);
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random back-pressure, stalls of the same shape as the gaps.
  initial begin
    int stall_left;
    int gap;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          stall_left = gap - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    leaf_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %h slot %h read_value %h",
                 $time, status_o, slot_o, read_value_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %h actual %h", $time, want.status, status_o);
          mismatch_count++;
        end
        if (slot_o !== want.slot) begin
          $display("%0t: slot expected %h actual %h", $time, want.slot, slot_o);
          mismatch_count++;
        end
        if (read_value_o !== want.rd) begin
          $display("%0t: read_value expected %h actual %h", $time, want.rd, read_value_o);
          mismatch_count++;
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
sv/fst_pkg.sv
sv/fst_ram.sv
sv/fst_tag_array.sv
sv/fingerprinted_slot_table_unit.sv
bench/fingerprinted_slot_table_unit_test.sv
